// ----- hw/rtl/sdbc_pkg.sv -----
`default_nettype none

package sdbc_pkg;

    // Sample width; the transaction structs below are built on it.
    localparam int SAMPLE_BITS = 24;
    localparam int STEP_W = SAMPLE_BITS - 1;
    localparam int PHASE_FRAC_BITS_DEFAULT = 24;

    typedef enum logic [0:0] {
        REG_PHASE_INCREMENT = 1'b0,
        REG_QUANT_STEP      = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_sample;
        logic signed [SAMPLE_BITS-1:0] right_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIVIDE,
        ST_SCALE,
        ST_SAT,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sdbc_divider.sv -----
`default_nettype none

module sdbc_divider #(
    parameter int DIVIDEND_W = 25,
    parameter int DIVISOR_W  = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic [DIVIDEND_W-1:0]      quotient
);

    localparam int CntW = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic                  run_reg, run_next;
    logic                  done_reg, done_next;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W:0]    rem_sub;
    logic                  ge;

    // One restoring step per cycle: the dividend shifts out at the top while
    // quotient bits shift in at the bottom.
    always_comb begin
        rem_sh   = {rem_reg, quo_reg[DIVIDEND_W-1]};
        ge       = rem_sh >= {1'b0, divisor};
        rem_sub  = rem_sh - {1'b0, divisor};
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = CntW'(DIVIDEND_W);
            run_next = 1'b1;
        end else if (run_reg) begin
            quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
            rem_next = ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
            cnt_next = cnt_reg - CntW'(1);
            if (cnt_reg == CntW'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/stereo_decimator_bitcrusher.sv -----
`default_nettype none

// Stereo sample-and-hold decimator with bit crusher. Each input transaction
// carries one signed Q1.23 stereo pair; each one yields exactly one output
// transaction. A phase accumulator adds phase_increment (register 0, Q1.24,
// values above 1.0 act as 1.0) and reloads the held pair whenever the sum
// rounds to a nonzero count. The held pair is then quantized to multiples of
// quant_step (register 1, Q0.23): twice the sample plus the step, divided
// by twice the step with its magnitude truncated toward zero, times the
// step, saturating; a step of zero passes the held pair straight through.
// Configuration may only be written while the block is idle. In ST_START a
// zero step copies the held pair and ST_EMIT loads it into the output
// register. With a nonzero step each channel, left then right, passes
// through ST_START, ST_DIVIDE, ST_SCALE and ST_SAT on one bit-serial
// divider shared by both channels, and ST_EMIT then loads the result.
// ST_EMIT waits while the output register holds a result not yet taken.
// The input is not ready while a transaction is in progress, but a finished
// result may wait in the output register while the next transaction is
// accepted.

module stereo_decimator_bitcrusher #(
    parameter int PHASE_FRAC_BITS = sdbc_pkg::PHASE_FRAC_BITS_DEFAULT
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire sdbc_pkg::in_item_t   s_data,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output sdbc_pkg::out_item_t       m_data,

    input  wire logic                 cfg_we,
    input  wire sdbc_pkg::cfg_reg_t   cfg_addr,
    input  wire logic [((PHASE_FRAC_BITS + 1 > sdbc_pkg::STEP_W) ?
                        PHASE_FRAC_BITS + 1 : sdbc_pkg::STEP_W) - 1:0] cfg_wdata
);

    import sdbc_pkg::*;

    localparam int P   = PHASE_FRAC_BITS;
    localparam int S   = SAMPLE_BITS;
    localparam int PhW = P + 3;
    localparam int PrW = 2 * S + 2;

    localparam logic [P:0]            ONE_U   = (P + 1)'(64'd1 << P);
    localparam logic signed [P:0]     HALF_A  = (P + 1)'(64'd1 << (P - 1));
    localparam logic signed [PhW-1:0] HALF_W  = PhW'(64'd1 << (P - 1));
    localparam logic signed [PhW-1:0] NHALF_W = -HALF_W;
    localparam logic signed [PrW-1:0] SAT_HI  = PrW'((64'd1 << (S - 1)) - 64'd1);
    localparam logic signed [PrW-1:0] SAT_LO  = -SAT_HI - PrW'(1);

    // Configuration registers.
    logic [P:0]        inc_reg;
    logic [STEP_W-1:0] step_reg;

    // Block state.
    logic signed [P:0]   acc_reg, acc_next;
    logic signed [S-1:0] hold_l_reg, hold_r_reg;

    state_t state_reg, state_next;
    logic   ch_reg;
    logic   neg_reg;
    logic signed [S-1:0]   res_l_reg, res_r_reg;
    logic signed [PrW-1:0] prod_reg;
    out_item_t out_reg;
    logic      out_valid_reg;

    logic s_accept;
    logic div_start;
    logic out_load;
    logic div_done;
    logic [S:0] div_quo;

    // Phase accumulator: add, round half away from zero, keep the remainder.
    logic [P:0]            inc_sat;
    logic signed [PhW-1:0] ph, ph_rnd;
    logic                  load;

    always_comb begin
        inc_sat = (inc_reg > ONE_U) ? ONE_U : inc_reg;
        ph      = $signed({{2{acc_reg[P]}}, acc_reg}) + $signed({2'b00, inc_sat});
        ph_rnd  = ph + HALF_W;
        if (!ph[PhW-1]) begin
            // The count is the bits above the fraction; the remainder is the
            // fraction re-centred about zero.
            load     = |ph_rnd[PhW-1:P];
            acc_next = $signed({1'b0, ph_rnd[P-1:0]}) - HALF_A;
        end else if (ph == NHALF_W) begin
            // Exactly minus one half rounds to minus one.
            load     = 1'b1;
            acc_next = HALF_A;
        end else begin
            load     = 1'b0;
            acc_next = ph[P:0];
        end
    end

    // Rounding numerator 2x + step for the channel in progress; the divider
    // works on magnitudes, so the sign is kept aside.
    logic signed [S-1:0] hold_sel;
    logic signed [S+1:0] num;
    logic [S+1:0]        num_mag;
    logic signed [S+1:0] q_signed;
    logic signed [PrW-1:0] prod_next;
    logic signed [S-1:0]   sat_val;

    always_comb begin
        hold_sel  = ch_reg ? hold_r_reg : hold_l_reg;
        num       = $signed({hold_sel[S-1], hold_sel, 1'b0}) + $signed({3'b000, step_reg});
        num_mag   = num[S+1] ? -num : num;
        q_signed  = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        prod_next = q_signed * $signed({1'b0, step_reg});
        if (prod_reg > SAT_HI) begin
            sat_val = SAT_HI[S-1:0];
        end else if (prod_reg < SAT_LO) begin
            sat_val = SAT_LO[S-1:0];
        end else begin
            sat_val = prod_reg[S-1:0];
        end
    end

    sdbc_divider #(
        .DIVIDEND_W (S + 1),
        .DIVISOR_W  (S)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (num_mag[S:0]),
        .divisor  ({step_reg, 1'b0}),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Sequencer: next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                state_next = (step_reg == '0) ? ST_EMIT : ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (div_done) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                state_next = ST_SAT;
            end
            ST_SAT: begin
                state_next = ch_reg ? ST_EMIT : ST_START;
            end
            ST_EMIT: begin
                if (!out_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer: outputs.
    always_comb begin
        s_ready   = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
            end
            ST_START: begin
                div_start = step_reg != '0;
            end
            ST_EMIT: begin
                out_load = !out_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            inc_reg       <= ONE_U;
            step_reg      <= '0;
            acc_reg       <= '0;
            hold_l_reg    <= '0;
            hold_r_reg    <= '0;
            ch_reg        <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_we) begin
                case (cfg_addr)
                    REG_PHASE_INCREMENT: inc_reg  <= cfg_wdata[P:0];
                    REG_QUANT_STEP:      step_reg <= cfg_wdata[STEP_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (s_accept) begin
                acc_reg <= acc_next;
                ch_reg  <= 1'b0;
                if (load) begin
                    hold_l_reg <= s_data.left_sample;
                    hold_r_reg <= s_data.right_sample;
                end
            end else if (state_reg == ST_SAT) begin
                ch_reg <= 1'b1;
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end

        // Datapath registers.
        if (state_reg == ST_START) begin
            neg_reg <= num[S+1];
            if (step_reg == '0) begin
                res_l_reg <= hold_l_reg;
                res_r_reg <= hold_r_reg;
            end
        end
        if (state_reg == ST_SCALE) begin
            prod_reg <= prod_next;
        end
        if (state_reg == ST_SAT) begin
            if (ch_reg) begin
                res_r_reg <= sat_val;
            end else begin
                res_l_reg <= sat_val;
            end
        end
        if (out_load) begin
            out_reg.left_out  <= res_l_reg;
            out_reg.right_out <= res_r_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire
